FILE: rtl/pwr_pkg.sv
// Shared constants, types and helper functions of the pooling window reducer.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package pwr_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int ACC_BITS       = 22;
   localparam int INDEX_BITS     = 6;
   localparam int COORD_BITS     = 10;
   localparam int CFG_BITS       = 11;
   localparam int KERNEL_BITS    = 4;
   localparam int PHASE_BITS     = 3;
   localparam int DIVISOR_BITS   = 7;
   localparam int CSR_INDEX_BITS = 3;
   localparam int LINE_DEPTH     = 1 << COORD_BITS;

   localparam logic [KERNEL_BITS-1:0] MAX_KERNEL = 4'd8;
   localparam logic [CFG_BITS-1:0]    MAX_WIDTH  = 11'd1024;
   localparam logic [CFG_BITS-1:0]    MAX_HEIGHT = 11'd1024;

   localparam logic MODE_MAX  = 1'b0;
   localparam logic MODE_MEAN = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_SIZE = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IN_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IN_HEIGHT   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_WIDTH   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_HEIGHT  = 3'd5;

   typedef struct packed {
      logic req_ready;
      logic commit;
      logic div_start;
      logic load_out;
   } pwr_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic has_result;
      logic mean_mode;
      logic out_free;
   } pwr_status_type;

   function automatic logic [CFG_BITS-1:0] clamp_size(input logic [CFG_BITS-1:0] v,
                                                      input logic [CFG_BITS-1:0] hi);
      logic [CFG_BITS-1:0] r;
      r = v;
      if (v == '0) r = {{(CFG_BITS-1){1'b0}}, 1'b1};
      else if (v > hi) r = hi;
      return r;
   endfunction

   function automatic logic [KERNEL_BITS-1:0] clamp_kernel(input logic [KERNEL_BITS-1:0] v);
      logic [KERNEL_BITS-1:0] r;
      r = v;
      if (v == '0) r = {{(KERNEL_BITS-1){1'b0}}, 1'b1};
      else if (v > MAX_KERNEL) r = MAX_KERNEL;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pwr_req_if.sv
// Input sample channel: valid, ready and one signed sample.
// Depends on pwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pwr_req_if import pwr_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/pwr_rsp_if.sv
// Result channel: valid, ready and one pooled result with its position.
// Depends on pwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pwr_rsp_if import pwr_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] pooled_value;
   logic [INDEX_BITS-1:0]         window_index;
   logic [COORD_BITS-1:0]         out_col;
   logic [COORD_BITS-1:0]         out_row;
   logic                          plane_last;

   modport source (output valid, output pooled_value, output window_index,
                   output out_col, output out_row, output plane_last, input ready);
   modport sink (input valid, input pooled_value, input window_index,
                 input out_col, input out_row, input plane_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/pwr_divider.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Divides the signed window sum by kernel_size squared. Depends on pwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwr_divider import pwr_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [ACC_BITS-1:0]    dividend,
   input  wire logic [DIVISOR_BITS-1:0]       divisor,
   output logic                               done,
   output logic signed [SAMPLE_BITS-1:0]      quotient
);

   localparam int COUNT_BITS = $clog2(ACC_BITS + 1);

   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    done_ff, done_in;
   logic [ACC_BITS-1:0]     dq_ff, dq_in;
   logic [DIVISOR_BITS-1:0] rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0] div_ff, div_in;
   logic                    neg_ff, neg_in;

   logic [DIVISOR_BITS:0]   rem_shift;
   logic [DIVISOR_BITS:0]   rem_diff;
   logic [ACC_BITS-1:0]     magnitude;
   logic [ACC_BITS-1:0]     signed_q;

   assign magnitude = dividend[ACC_BITS-1] ? ACC_BITS'(-dividend) : ACC_BITS'(dividend);
   assign rem_shift = {rem_ff, dq_ff[ACC_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};

   always_comb begin
      count_in = count_ff;
      done_in  = done_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      if (start) begin
         count_in = COUNT_BITS'(ACC_BITS);
         done_in  = 1'b0;
         dq_in    = magnitude;
         rem_in   = '0;
         div_in   = divisor;
         neg_in   = dividend[ACC_BITS-1];
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         if (rem_shift >= {1'b0, div_ff}) begin
            rem_in = rem_diff[DIVISOR_BITS-1:0];
            dq_in  = {dq_ff[ACC_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DIVISOR_BITS-1:0];
            dq_in  = {dq_ff[ACC_BITS-2:0], 1'b0};
         end
         if (count_ff == {{(COUNT_BITS-1){1'b0}}, 1'b1}) done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign signed_q = neg_ff ? (~dq_ff + 1'b1) : dq_ff;
   assign quotient = signed_q[SAMPLE_BITS-1:0];
   assign done     = done_ff;

   a_start_clears_done: assert property (@(posedge clock) disable iff (reset)
      start |=> !done_ff && (count_ff == COUNT_BITS'(ACC_BITS)))
      else $error("divider start did not restart the iteration");

endmodule

`default_nettype wire

FILE: rtl/pwr_ctrl.sv
// Controller state machine: sequences accept, line-store update, divide and emit.
// Depends on pwr_pkg; drives the datapath and divider through command signals.
`timescale 1ns / 1ps
`default_nettype none

module pwr_ctrl import pwr_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire pwr_status_type status,
   input  wire logic           div_done,
   output pwr_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.commit = 1'b1;
            if (!status.has_result) begin
               state_in = ST_IDLE;
            end else if (status.mean_mode) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded over an untaken result");

   a_single_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> (state_ff != ST_UPDATE))
      else $error("line store updated twice for one sample");

endmodule

`default_nettype wire

FILE: rtl/pwr_datapath.sv
// Datapath: configuration registers, raster counters, line store, max/sum update
// and the output register. Depends on pwr_pkg and the two channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module pwr_datapath import pwr_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [CFG_BITS-1:0]         csr_wdata,
   pwr_req_if.sink                          req_chan,
   pwr_rsp_if.source                        rsp_chan,
   input  wire pwr_cmd_type                 cmd,
   output pwr_status_type                   status,
   output logic signed [ACC_BITS-1:0]       div_dividend,
   output logic [DIVISOR_BITS-1:0]          div_divisor,
   input  wire logic signed [SAMPLE_BITS-1:0] div_quotient
);

   // configuration
   logic                   mode_ff;
   logic [KERNEL_BITS-1:0] kernel_ff;
   logic [CFG_BITS-1:0]    in_width_ff, in_height_ff, out_width_ff, out_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_MAX;
         kernel_ff     <= 4'd2;
         in_width_ff   <= 11'd1024;
         in_height_ff  <= 11'd1024;
         out_width_ff  <= 11'd512;
         out_height_ff <= 11'd512;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:        mode_ff       <= csr_wdata[0];
            CSR_KERNEL_SIZE: kernel_ff     <= csr_wdata[KERNEL_BITS-1:0];
            CSR_IN_WIDTH:    in_width_ff   <= csr_wdata;
            CSR_IN_HEIGHT:   in_height_ff  <= csr_wdata;
            CSR_OUT_WIDTH:   out_width_ff  <= csr_wdata;
            CSR_OUT_HEIGHT:  out_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [KERNEL_BITS-1:0]   k;
   logic [CFG_BITS-1:0]      iw, ih, ow, oh;
   logic [2*KERNEL_BITS-1:0] kk;

   assign k  = clamp_kernel(kernel_ff);
   assign iw = clamp_size(in_width_ff, MAX_WIDTH);
   assign ih = clamp_size(in_height_ff, MAX_HEIGHT);
   assign ow = clamp_size(out_width_ff, MAX_WIDTH);
   assign oh = clamp_size(out_height_ff, MAX_HEIGHT);
   assign kk = k * k;

   // raster position
   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [COORD_BITS-1:0] occ_ff, occ_in, orc_ff, orc_in;
   logic [PHASE_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;

   logic [COORD_BITS:0]   col_step, row_step;
   logic [PHASE_BITS:0]   cx_step, cy_step;

   assign col_step = {1'b0, col_ff} + 1'b1;
   assign row_step = {1'b0, row_ff} + 1'b1;
   assign cx_step  = {1'b0, cx_ff} + 1'b1;
   assign cy_step  = {1'b0, cy_ff} + 1'b1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      occ_in = occ_ff;
      orc_in = orc_ff;
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      if (cmd.commit) begin
         col_in = col_step[COORD_BITS-1:0];
         cx_in  = cx_step[PHASE_BITS-1:0];
         if (cx_step >= k) begin
            cx_in  = '0;
            occ_in = occ_ff + 1'b1;
         end
         if (col_step >= iw) begin
            col_in = '0;
            cx_in  = '0;
            occ_in = '0;
            row_in = row_step[COORD_BITS-1:0];
            cy_in  = cy_step[PHASE_BITS-1:0];
            if (cy_step >= k) begin
               cy_in  = '0;
               orc_in = orc_ff + 1'b1;
            end
            if (row_step >= ih) begin
               row_in = '0;
               cy_in  = '0;
               orc_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         occ_ff <= '0;
         orc_ff <= '0;
         cx_ff  <= '0;
         cy_ff  <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         occ_ff <= occ_in;
         orc_ff <= orc_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
      end
   end

   // sample capture
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          req_fire;

   assign req_fire       = req_chan.valid && cmd.req_ready;
   assign req_chan.ready = cmd.req_ready;

   always_ff @(posedge clock) begin
      if (req_fire) sample_ff <= req_chan.sample;
   end

   // line store, one partial result per output column
   logic signed [ACC_BITS-1:0] line_acc_mem [LINE_DEPTH];
   logic [INDEX_BITS-1:0]      line_idx_mem [LINE_DEPTH];
   logic signed [ACC_BITS-1:0] acc_rd_ff;
   logic [INDEX_BITS-1:0]      idx_rd_ff;

   logic                       active, first, last;
   logic signed [ACC_BITS-1:0] acc_base, acc_new, sample_ext;
   logic [INDEX_BITS-1:0]      idx_base, idx_new;
   logic [2*KERNEL_BITS-1:0]   position;

   assign active     = ({1'b0, occ_ff} < ow) && ({1'b0, orc_ff} < oh);
   assign first      = (cx_ff == '0) && (cy_ff == '0);
   assign last       = ({1'b0, cx_ff} == k - 1'b1) && ({1'b0, cy_ff} == k - 1'b1);
   assign acc_base   = first ? '0 : acc_rd_ff;
   assign idx_base   = first ? '0 : idx_rd_ff;
   assign sample_ext = ACC_BITS'(sample_ff);
   assign position   = {{(KERNEL_BITS+1){1'b0}}, cy_ff} * {{KERNEL_BITS{1'b0}}, k}
                       + {{(KERNEL_BITS+1){1'b0}}, cx_ff};

   always_comb begin
      acc_new = acc_base;
      idx_new = idx_base;
      if (mode_ff == MODE_MEAN) begin
         acc_new = acc_base + sample_ext;
         idx_new = '0;
      end else if (sample_ext > acc_base) begin
         acc_new = sample_ext;
         idx_new = position[INDEX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && active) begin
         line_acc_mem[occ_ff] <= acc_new;
         line_idx_mem[occ_ff] <= idx_new;
      end
      acc_rd_ff <= line_acc_mem[occ_ff];
      idx_rd_ff <= line_idx_mem[occ_ff];
   end

   assign div_dividend = acc_new;
   assign div_divisor  = kk[DIVISOR_BITS-1:0];

   // result waiting for emit
   logic signed [SAMPLE_BITS-1:0] pend_value_ff;
   logic [INDEX_BITS-1:0]         pend_index_ff;
   logic [COORD_BITS-1:0]         pend_col_ff, pend_row_ff;
   logic                          pend_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         pend_value_ff <= acc_new[SAMPLE_BITS-1:0];
         pend_index_ff <= (mode_ff == MODE_MEAN) ? '0 : idx_new;
         pend_col_ff   <= occ_ff;
         pend_row_ff   <= orc_ff;
         pend_last_ff  <= ({1'b0, occ_ff} == ow - 1'b1) && ({1'b0, orc_ff} == oh - 1'b1);
      end
   end

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff;
   logic [INDEX_BITS-1:0]         rsp_index_ff;
   logic [COORD_BITS-1:0]         rsp_col_ff, rsp_row_ff;
   logic                          rsp_last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      if (cmd.load_out) begin
         rsp_value_ff <= (mode_ff == MODE_MEAN) ? div_quotient : pend_value_ff;
         rsp_index_ff <= pend_index_ff;
         rsp_col_ff   <= pend_col_ff;
         rsp_row_ff   <= pend_row_ff;
         rsp_last_ff  <= pend_last_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pooled_value = rsp_value_ff;
   assign rsp_chan.window_index = rsp_index_ff;
   assign rsp_chan.out_col      = rsp_col_ff;
   assign rsp_chan.out_row      = rsp_row_ff;
   assign rsp_chan.plane_last   = rsp_last_ff;

   assign status.req_valid  = req_chan.valid;
   assign status.has_result = active && last;
   assign status.mean_mode  = (mode_ff == MODE_MEAN);
   assign status.out_free   = !rsp_valid_ff || rsp_chan.ready;

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_out))
      else $error("result valid raised without a load");

endmodule

`default_nettype wire

FILE: rtl/pool_window_reduce_top.sv
// Non-overlapping 2-D max / mean pooling of a raster stream of signed Q8.8 samples.
// One sample is taken at a time, and no new sample is accepted until the last one is done;
// a sample that closes a window in mean mode waits for the 22-step restoring divider
// that divides the window sum by kernel_size squared. A result that is not taken holds
// the block once the next result is ready. The line store (one 28-bit entry per output
// column, read-modify-write through a registered read) is not cleared after reset: each
// window's first sample initializes its entry, and no clearing pass runs. Registers
// written through the csr port take effect on the next sample; write them only while no
// sample is in flight.
// Depends on pwr_pkg, pwr_req_if, pwr_rsp_if, pwr_ctrl, pwr_datapath, pwr_divider.
`timescale 1ns / 1ps
`default_nettype none

module pool_window_reduce_top import pwr_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   pwr_req_if.sink                        req_chan,
   pwr_rsp_if.source                      rsp_chan,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]       csr_wdata
);

   pwr_cmd_type                   cmd;
   pwr_status_type                status;
   logic                          div_done;
   logic signed [ACC_BITS-1:0]    div_dividend;
   logic [DIVISOR_BITS-1:0]       div_divisor;
   logic signed [SAMPLE_BITS-1:0] div_quotient;

   pwr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .div_done (div_done),
      .cmd      (cmd)
   );

   pwr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .cmd          (cmd),
      .status       (status),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_quotient (div_quotient)
   );

   pwr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking bench for pool_window_reduce_top: raster planes in, pooled windows out.
// Predicts every window result in step with accepted samples and checks each transfer.
// Depends on pwr_pkg, pwr_req_if, pwr_rsp_if and the block itself.
`timescale 1ns / 1ps

module tb;
   import pwr_pkg::*;

   localparam int unsigned CYCLE_LIMIT       = 1000000;
   localparam int unsigned SETTLE_CYCLES     = 40;
   localparam int unsigned RANDOM_SAMPLES    = 1400;
   localparam int unsigned SAMPLES_ANY       = 0;
   localparam int unsigned SAMPLES_NEGATIVE  = 1;
   localparam int unsigned SAMPLES_NEAR_ZERO = 2;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value;
      logic [INDEX_BITS-1:0]         index;
      logic [COORD_BITS-1:0]         col;
      logic [COORD_BITS-1:0]         row;
      logic                          last;
   } window_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      send_valid  = 1'b0;
   sample_type                send_sample = '0;
   logic                      take_ready  = 1'b0;
   logic                      csr_we      = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = CSR_MODE;
   logic [CFG_BITS-1:0]       csr_wdata   = '0;
   logic                      req_taken   = 1'b0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned fail_count     = 0;
   int unsigned cycle_count    = 0;

   sample_type        samples_to_send[$];
   window_result_type expected_windows[$];

   // shadow registers, raw as written
   logic                   cfg_mode   = MODE_MAX;
   logic [KERNEL_BITS-1:0] cfg_kernel = 4'd2;
   logic [CFG_BITS-1:0]    cfg_in_w   = 11'd1024;
   logic [CFG_BITS-1:0]    cfg_in_h   = 11'd1024;
   logic [CFG_BITS-1:0]    cfg_out_w  = 11'd512;
   logic [CFG_BITS-1:0]    cfg_out_h  = 11'd512;

   // pooling state
   longint      line_sum [LINE_DEPTH];
   bit [5:0]    line_best [LINE_DEPTH];
   int unsigned col_pos, row_pos, col_phase, row_phase, out_col_cnt, out_row_cnt;

   pwr_req_if req_if ();
   pwr_rsp_if rsp_if ();

   assign req_if.valid  = send_valid;
   assign req_if.sample = send_sample;
   assign rsp_if.ready  = take_ready;

   pool_window_reduce_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int unsigned saturate(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit pool_next_sample(input sample_type s, output window_result_type r);
      int unsigned k, iw, ih, ow, oh, cx, cy, slot;
      longint      acc;
      longint      v;
      bit [5:0]    best;
      bit          hit;
      k   = saturate(cfg_kernel, 8);
      iw  = saturate(cfg_in_w, 1024);
      ih  = saturate(cfg_in_h, 1024);
      ow  = saturate(cfg_out_w, 1024);
      oh  = saturate(cfg_out_h, 1024);
      cx  = col_phase;
      cy  = row_phase;
      hit = 1'b0;
      r   = '0;
      if (out_col_cnt < ow && out_row_cnt < oh) begin
         slot = out_col_cnt % LINE_DEPTH;
         acc  = line_sum[slot];
         best = line_best[slot];
         if (cx == 0 && cy == 0) begin
            acc  = 0;
            best = '0;
         end
         if (cfg_mode == MODE_MAX) begin
            if (s > acc) begin
               acc  = s;
               best = 6'((cy * k + cx) % 64);
            end
         end else begin
            acc  = acc + s;
            best = '0;
         end
         line_sum[slot]  = acc;
         line_best[slot] = best;
         if (cx == k - 1 && cy == k - 1) begin
            v       = (cfg_mode == MODE_MAX) ? acc : acc / longint'(k * k);
            r.value = v[SAMPLE_BITS-1:0];
            r.index = (cfg_mode == MODE_MAX) ? best : '0;
            r.col   = out_col_cnt[COORD_BITS-1:0];
            r.row   = out_row_cnt[COORD_BITS-1:0];
            r.last  = (out_col_cnt == ow - 1 && out_row_cnt == oh - 1);
            hit     = 1'b1;
         end
      end
      col_pos++;
      col_phase++;
      if (col_phase >= k) begin
         col_phase   = 0;
         out_col_cnt = (out_col_cnt + 1) & 32'h3FF;
      end
      if (col_pos >= iw) begin
         col_pos     = 0;
         col_phase   = 0;
         out_col_cnt = 0;
         row_pos++;
         row_phase++;
         if (row_phase >= k) begin
            row_phase   = 0;
            out_row_cnt = (out_row_cnt + 1) & 32'h3FF;
         end
         if (row_pos >= ih) begin
            row_pos     = 0;
            row_phase   = 0;
            out_row_cnt = 0;
         end
      end
      col_pos = col_pos & 32'h3FF;
      row_pos = row_pos & 32'h3FF;
      return hit;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // check result transfers, then predict from sample transfers
   always @(posedge clock) begin
      window_result_type got, want, due;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            got.value = rsp_if.pooled_value;
            got.index = rsp_if.window_index;
            got.col   = rsp_if.out_col;
            got.row   = rsp_if.out_row;
            got.last  = rsp_if.plane_last;
            if (expected_windows.size() == 0) begin
               $display("%0t unexpected result value %0d index %0d col %0d row %0d last %0d",
                        $time, got.value, got.index, got.col, got.row, got.last);
               fail_count++;
            end else begin
               want = expected_windows.pop_front();
               check_field("pooled_value", want.value, got.value);
               check_field("window_index", want.index, got.index);
               check_field("out_col", want.col, got.col);
               check_field("out_row", want.row, got.row);
               check_field("plane_last", want.last, got.last);
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (pool_next_sample(req_if.sample, due)) expected_windows.push_back(due);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         send_valid <= 1'b0;
      end else if (!send_valid || req_taken) begin
         if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            send_valid  <= 1'b1;
            send_sample <= samples_to_send.pop_front();
         end else begin
            send_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      take_ready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   function automatic sample_type pick_sample(int unsigned style);
      logic [SAMPLE_BITS-1:0] raw;
      raw = SAMPLE_BITS'($urandom);
      if ($urandom_range(0, 15) == 0) begin
         case ($urandom_range(0, 3))
            0: raw = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            1: raw = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            2: raw = '0;
            default: raw = '1;
         endcase
      end else if (style == SAMPLES_NEGATIVE) begin
         raw[SAMPLE_BITS-1] = 1'b1;
      end else if (style == SAMPLES_NEAR_ZERO) begin
         raw = SAMPLE_BITS'($urandom_range(0, 4)) - SAMPLE_BITS'(2);
      end
      return signed'(raw);
   endfunction

   function automatic int unsigned pick_style();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 12) return SAMPLES_ANY;
      if (r < 15) return SAMPLES_NEGATIVE;
      return SAMPLES_NEAR_ZERO;
   endfunction

   task automatic queue_rows(input int unsigned count, input int unsigned style);
      @(posedge clock);
      repeat (count) samples_to_send.push_back(pick_sample(style));
   endtask

   // hold until the sender is drained and every expected window has arrived
   task automatic wait_idle();
      while (samples_to_send.size() != 0 || send_valid || expected_windows.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MODE:        cfg_mode   = val[0];
         CSR_KERNEL_SIZE: cfg_kernel = val[KERNEL_BITS-1:0];
         CSR_IN_WIDTH:    cfg_in_w   = val;
         CSR_IN_HEIGHT:   cfg_in_h   = val;
         CSR_OUT_WIDTH:   cfg_out_w  = val;
         CSR_OUT_HEIGHT:  cfg_out_h  = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic m, input logic [KERNEL_BITS-1:0] k,
                            input logic [CFG_BITS-1:0] iw, input logic [CFG_BITS-1:0] ih,
                            input logic [CFG_BITS-1:0] ow, input logic [CFG_BITS-1:0] oh);
      wait_idle();
      write_reg(CSR_MODE, {{(CFG_BITS-1){1'b0}}, m});
      write_reg(CSR_KERNEL_SIZE, CFG_BITS'(k));
      write_reg(CSR_IN_WIDTH, iw);
      write_reg(CSR_IN_HEIGHT, ih);
      write_reg(CSR_OUT_WIDTH, ow);
      write_reg(CSR_OUT_HEIGHT, oh);
   endtask

   function automatic logic [CFG_BITS-1:0] encode_size(int unsigned v);
      if (v == 1 && $urandom_range(0, 2) == 0) return '0;
      return CFG_BITS'(v);
   endfunction

   function automatic int unsigned grid_size(int unsigned fit);
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r < 12) return fit;
      if (r < 14) return $urandom_range(1, fit);
      return fit + $urandom_range(1, 2);
   endfunction

   task automatic random_configure(output int unsigned plane_size);
      int unsigned pick, k, fit_w, fit_h, iw, ih;
      logic [KERNEL_BITS-1:0] k_raw;
      pick  = $urandom_range(0, 9);
      k     = (pick < 6) ? $urandom_range(1, 3) :
              (pick < 8) ? $urandom_range(4, 5) : $urandom_range(6, 8);
      fit_w = $urandom_range(1, (k <= 2) ? 6 : (k <= 4) ? 3 : 1);
      fit_h = $urandom_range(1, (k <= 2) ? 4 : (k <= 4) ? 2 : 1);
      iw    = fit_w * k + $urandom_range(0, k - 1);
      ih    = fit_h * k + $urandom_range(0, k - 1);
      k_raw = KERNEL_BITS'(k);
      if (k == 1 && $urandom_range(0, 3) == 0) k_raw = '0;
      if (k == 8 && $urandom_range(0, 1) == 0) k_raw = KERNEL_BITS'($urandom_range(9, 15));
      plane_size = iw * ih;
      configure(1'($urandom_range(0, 1)), k_raw, encode_size(iw), encode_size(ih),
                encode_size(grid_size(fit_w)), encode_size(grid_size(fit_h)));
   endtask

   initial begin
      int unsigned group, random_items, plane_size;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // max: all-negative window floors at zero, ties keep the first maximum
      configure(MODE_MAX, 4'd2, 11'd4, 11'd2, 11'd2, 11'd1);
      @(posedge clock);
      samples_to_send = {samples_to_send, 16'h8000, 16'hFFFF, 16'h0005, 16'h7FFF,
                         16'hFFFB, 16'h8000, 16'h7FFF, 16'h0007};
      // mean: full-scale sums, negative sum truncates toward zero
      configure(MODE_MEAN, 4'd2, 11'd4, 11'd2, 11'd2, 11'd1);
      @(posedge clock);
      samples_to_send = {samples_to_send, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                         16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF};
      // zero kernel and zero sizes act as one
      configure(MODE_MEAN, 4'd0, 11'd0, 11'd0, 11'd0, 11'd0);
      @(posedge clock);
      samples_to_send = {samples_to_send, 16'h7FFF, 16'h8000, 16'h0000};
      // output grid wider than the plane: trailing window never completes
      configure(MODE_MAX, 4'd2, 11'd3, 11'd2, 11'd4, 11'd1);
      @(posedge clock);
      samples_to_send = {samples_to_send, 16'h0064, 16'hFFFD, 16'h0007,
                         16'h00C8, 16'h0032, 16'h0009};

      // kernel shrinks mid-plane after a full drain: row phase lands beyond the kernel
      configure(MODE_MAX, 4'd4, 11'd8, 11'd12, 11'd2, 11'd3);
      queue_rows(7 * 8, SAMPLES_ANY);
      wait_idle();
      write_reg(CSR_KERNEL_SIZE, 11'd2);
      queue_rows(5 * 8, SAMPLES_ANY);

      group        = 0;
      random_items = 0;
      while (random_items < RANDOM_SAMPLES) begin
         case (group % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         if (group == 6) begin
            // widest row, oversized values saturate
            configure(1'($urandom_range(0, 1)), 4'd0, 11'd2047, 11'd0, 11'd2047, 11'd0);
            queue_rows(1024, pick_style());
            random_items += 1024;
         end else begin
            random_configure(plane_size);
            repeat ($urandom_range(1, 3)) begin
               queue_rows(plane_size, pick_style());
               random_items += plane_size;
            end
         end
         group++;
      end
      wait_idle();

      if (fail_count == 0 && expected_windows.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
